[rtl/core/h264dp_pkg.sv]
// ----------------------------------------------------------------------------
// h264dp_pkg
// Shared types and constants of the H.264 RTP depacketiser: NAL codes, result
// kinds and the command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package h264dp_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    // NAL unit types and header fields.
    localparam logic [4:0] NAL_IDR        = 5'd5;
    localparam logic [4:0] NAL_SPS        = 5'd7;
    localparam logic [4:0] NAL_PPS        = 5'd8;
    localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
    localparam logic [4:0] NAL_STAP_A     = 5'd24;
    localparam logic [4:0] NAL_FU_A       = 5'd28;
    localparam logic [7:0] NAL_TYPE_MASK  = 8'h1F;
    localparam logic [7:0] NAL_FNRI_MASK  = 8'hE0;
    localparam int         FU_START_BIT   = 7;
    localparam int         FU_END_BIT     = 6;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_END   = 2'd1,
        KIND_SPS   = 2'd2,
        KIND_PPS   = 2'd3
    } t_kind;

    // Where the bytes of the current unit go.
    typedef enum logic [1:0] {
        DEST_FRAME = 2'd0,
        DEST_NONE  = 2'd1,
        DEST_SPS   = 2'd2,
        DEST_PPS   = 2'd3
    } t_dest;

    // STAP-A parse phase.
    typedef enum logic [2:0] {
        STAP_LEN_HI = 3'b001,
        STAP_LEN_LO = 3'b010,
        STAP_BODY   = 3'b100
    } t_stap;

    // Output steps of one command, in emission order.
    localparam int STEP_PRE     = 0;
    localparam int STEP_SC_LAST = 4;
    localparam int STEP_BYTE    = 5;
    localparam int STEP_POST    = 6;
    localparam int STEPS        = 7;

    typedef struct packed {
        logic        pre_close;
        logic        pre_key;
        logic [31:0] pre_ts;
        logic        start_code;
        logic        byte_en;
        t_kind       byte_kind;
        logic [7:0]  byte_val;
        logic        byte_ue;
        logic        post_close;
        logic        post_key;
        logic [31:0] post_ts;
    } t_cmd;

endpackage

[rtl/core/h264dp_front.sv]
// ----------------------------------------------------------------------------
// h264dp_front
// Accepts payload bytes, tracks the packetisation state and turns each byte
// into one command describing the results it causes.
// ----------------------------------------------------------------------------
module h264dp_front import h264dp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_byte_first,
    input  logic        i_byte_last,
    input  logic [15:0] i_packet_length,
    input  logic        i_marker,
    input  logic [31:0] i_rtp_timestamp,
    input  logic        i_space,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [15:0] r_pos, n_pos;
    logic [4:0]  r_type, n_type;
    logic [7:0]  r_fu_ind, n_fu_ind;
    logic [7:0]  r_fhs, n_fhs;
    logic [7:0]  r_ulh, n_ulh;
    logic [15:0] r_rem, n_rem;
    t_dest       r_dest, n_dest;
    logic        r_stopped, n_stopped;
    logic        r_open, n_open;
    logic        r_key, n_key;
    logic [31:0] r_ts, n_ts;
    t_stap       r_phase, n_phase;

    t_cmd        cmd;
    logic        accept;

    always_comb begin
        logic [15:0] pos;
        logic [15:0] size;
        logic [4:0]  nt;
        logic        single;

        pos       = i_byte_first ? 16'd0 : r_pos;
        n_pos     = (pos != 16'hFFFF) ? pos + 16'd1 : pos;
        n_type    = r_type;
        n_fu_ind  = r_fu_ind;
        n_fhs     = r_fhs;
        n_ulh     = r_ulh;
        n_rem     = r_rem;
        n_dest    = r_dest;
        n_stopped = r_stopped;
        n_open    = r_open;
        n_key     = r_key;
        n_ts      = r_ts;
        n_phase   = r_phase;
        cmd       = '0;
        size      = {r_ulh, i_payload_byte};
        nt        = i_payload_byte[4:0];

        if (pos == 16'd0) begin
            n_type    = i_payload_byte[4:0];
            n_fu_ind  = i_payload_byte;
            n_fhs     = '0;
            n_ulh     = '0;
            n_rem     = '0;
            n_dest    = DEST_NONE;
            n_stopped = 1'b0;
            n_phase   = STAP_LEN_HI;
        end
        single = (n_type != 5'd0) && (n_type <= NAL_SINGLE_MAX);

        if (single) begin
            if (pos == 16'd0) begin
                if (n_type == NAL_SPS) begin
                    n_dest = DEST_SPS;
                end else if (n_type == NAL_PPS) begin
                    n_dest = DEST_PPS;
                end else begin
                    if (!n_open) begin
                        n_open = 1'b1;
                        n_key  = (n_type == NAL_IDR);
                        n_ts   = i_rtp_timestamp;
                    end
                    cmd.start_code = 1'b1;
                    n_dest = DEST_FRAME;
                end
            end
            if (n_dest != DEST_NONE) begin
                cmd.byte_en  = 1'b1;
                cmd.byte_val = i_payload_byte;
                cmd.byte_ue  = i_byte_last && (n_dest != DEST_FRAME);
                if (i_byte_last && (n_dest == DEST_FRAME) && i_marker && n_open) begin
                    cmd.post_close = 1'b1;
                    cmd.post_key   = n_key;
                    cmd.post_ts    = n_ts;
                    n_open = 1'b0;
                    n_key  = 1'b0;
                end
            end
        end else if (n_type == NAL_FU_A) begin
            if (pos == 16'd1) begin
                n_fhs = i_payload_byte;
                if (i_payload_byte[FU_START_BIT]) begin
                    if (n_open) begin
                        cmd.pre_close = 1'b1;
                        cmd.pre_key   = n_key;
                        cmd.pre_ts    = n_ts;
                        n_open = 1'b0;
                        n_key  = 1'b0;
                    end
                    n_open = 1'b1;
                    n_key  = (nt == NAL_IDR);
                    n_ts   = i_rtp_timestamp;
                    cmd.start_code = 1'b1;
                    cmd.byte_en    = 1'b1;
                    cmd.byte_val   = (n_fu_ind & NAL_FNRI_MASK)
                                   | (i_payload_byte & NAL_TYPE_MASK);
                end
            end else if ((pos >= 16'd2) && n_open) begin
                cmd.byte_en  = 1'b1;
                cmd.byte_val = i_payload_byte;
            end
            if (i_byte_last && (pos >= 16'd1) && n_open
                && (n_fhs[FU_END_BIT] || i_marker)) begin
                cmd.post_close = 1'b1;
                cmd.post_key   = n_key;
                cmd.post_ts    = n_ts;
                n_open = 1'b0;
                n_key  = 1'b0;
            end
        end else if (n_type == NAL_STAP_A) begin
            if ((pos >= 16'd1) && !n_stopped) begin
                unique case (r_phase)
                    STAP_LEN_HI: begin
                        if ({1'b0, pos} + 17'd2 <= {1'b0, i_packet_length}) begin
                            n_ulh   = i_payload_byte;
                            n_phase = STAP_LEN_LO;
                        end else begin
                            n_stopped = 1'b1;
                        end
                    end
                    STAP_LEN_LO: begin
                        if ({2'b0, pos} + 18'd1 + {2'b0, size}
                            > {2'b0, i_packet_length}) begin
                            n_stopped = 1'b1;
                        end else if (size == 16'd0) begin
                            n_phase = STAP_LEN_HI;
                        end else begin
                            n_rem   = size;
                            n_dest  = DEST_NONE;
                            n_phase = STAP_BODY;
                        end
                    end
                    STAP_BODY: begin
                        if (n_dest == DEST_NONE) begin
                            if (nt == NAL_SPS) begin
                                n_dest = DEST_SPS;
                            end else if (nt == NAL_PPS) begin
                                n_dest = DEST_PPS;
                            end else begin
                                if (!n_open) begin
                                    n_open = 1'b1;
                                    n_key  = 1'b0;
                                    n_ts   = i_rtp_timestamp;
                                end
                                if (nt == NAL_IDR) begin
                                    n_key = 1'b1;
                                end
                                cmd.start_code = 1'b1;
                                n_dest = DEST_FRAME;
                            end
                        end
                        cmd.byte_en  = 1'b1;
                        cmd.byte_val = i_payload_byte;
                        cmd.byte_ue  = (n_rem == 16'd1) && (n_dest != DEST_FRAME);
                        n_rem = n_rem - 16'd1;
                        if (n_rem == 16'd0) begin
                            n_phase = STAP_LEN_HI;
                        end
                    end
                    default: begin
                        n_phase = STAP_LEN_HI;
                    end
                endcase
            end
            if (i_byte_last && i_marker && n_open) begin
                cmd.post_close = 1'b1;
                cmd.post_key   = n_key;
                cmd.post_ts    = n_ts;
                n_open = 1'b0;
                n_key  = 1'b0;
            end
        end

        // Byte destination codes line up with the result kinds.
        unique case (n_dest)
            DEST_SPS: cmd.byte_kind = KIND_SPS;
            DEST_PPS: cmd.byte_kind = KIND_PPS;
            default:  cmd.byte_kind = KIND_FRAME;
        endcase

        if (cmd.byte_en && (n_type == NAL_STAP_A) && (n_rem == 16'd0)) begin
            n_dest = DEST_NONE;
        end

        if (i_byte_last) begin
            n_pos = 16'd0;
        end
    end

    assign o_in_ready = i_space;
    assign accept     = i_in_valid && i_space;
    assign o_push     = accept
                      && (cmd.pre_close || cmd.start_code || cmd.byte_en || cmd.post_close);
    assign o_cmd      = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_type    <= '0;
            r_fu_ind  <= '0;
            r_fhs     <= '0;
            r_ulh     <= '0;
            r_rem     <= '0;
            r_dest    <= DEST_FRAME;
            r_stopped <= 1'b0;
            r_open    <= 1'b0;
            r_key     <= 1'b0;
            r_ts      <= '0;
            r_phase   <= STAP_LEN_HI;
        end else if (accept) begin
            r_pos     <= n_pos;
            r_type    <= n_type;
            r_fu_ind  <= n_fu_ind;
            r_fhs     <= n_fhs;
            r_ulh     <= n_ulh;
            r_rem     <= n_rem;
            r_dest    <= n_dest;
            r_stopped <= n_stopped;
            r_open    <= n_open;
            r_key     <= n_key;
            r_ts      <= n_ts;
            r_phase   <= n_phase;
        end
    end

endmodule

[rtl/core/h264dp_queue.sv]
// ----------------------------------------------------------------------------
// h264dp_queue
// Small register FIFO of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module h264dp_queue import h264dp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_space,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_pop;

    assign o_space = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

[rtl/core/h264dp_back.sv]
// ----------------------------------------------------------------------------
// h264dp_back
// Expands each command into its result items, one per unstalled cycle, into an
// output register: frame end before, start code, byte, frame end after.
// ----------------------------------------------------------------------------
module h264dp_back import h264dp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_unit_end,
    output logic        o_keyframe,
    output logic [31:0] o_frame_timestamp,
    output logic        o_last
);

    t_cmd             r_cmd;
    logic [STEPS-1:0] r_mask, n_mask;
    logic [STEPS-1:0] sel, rem, load_mask;
    logic             emit, slot_free, pop;

    logic             r_valid;
    t_kind            r_kind, n_kind;
    logic [7:0]       r_byte, n_byte;
    logic             r_ue, n_ue;
    logic             r_key, n_key;
    logic [31:0]      r_ts, n_ts;
    logic             r_last;

    assign sel       = r_mask & (~r_mask + 1'b1);
    assign rem       = r_mask & ~sel;
    assign emit      = (r_mask != '0) && (!r_valid || i_out_ready);
    assign slot_free = (r_mask == '0) || (emit && (rem == '0));
    assign pop       = slot_free && i_q_valid;
    assign o_q_pop   = pop;
    assign load_mask = {i_q_cmd.post_close, i_q_cmd.byte_en,
                        {(STEP_SC_LAST - STEP_PRE){i_q_cmd.start_code}},
                        i_q_cmd.pre_close};

    always_comb begin
        n_kind = KIND_FRAME;
        n_byte = 8'd0;
        n_ue   = 1'b0;
        n_key  = 1'b0;
        n_ts   = 32'd0;
        if (sel[STEP_PRE]) begin
            n_kind = KIND_END;
            n_key  = r_cmd.pre_key;
            n_ts   = r_cmd.pre_ts;
        end else if (sel[STEP_SC_LAST]) begin
            n_byte = 8'd1;
        end else if (sel[STEP_BYTE]) begin
            n_kind = r_cmd.byte_kind;
            n_byte = r_cmd.byte_val;
            n_ue   = r_cmd.byte_ue;
        end else if (sel[STEP_POST]) begin
            n_kind = KIND_END;
            n_key  = r_cmd.post_key;
            n_ts   = r_cmd.post_ts;
        end

        if (pop) begin
            n_mask = load_mask;
        end else if (emit) begin
            n_mask = rem;
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_q_cmd;
        end
        if (emit) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_ue   <= n_ue;
            r_key  <= n_key;
            r_ts   <= n_ts;
            r_last <= (rem == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_valid;
    assign o_kind            = r_kind;
    assign o_out_byte        = r_byte;
    assign o_unit_end        = r_ue;
    assign o_keyframe        = r_key;
    assign o_frame_timestamp = r_ts;
    assign o_last            = r_last;

endmodule

[rtl/core/h264_rtp_depacketizer.sv]
// ----------------------------------------------------------------------------
// h264_rtp_depacketizer
// H.264 RTP depacketiser: single NAL units, FU-A and STAP-A in, Annex B
// frame bytes, SPS/PPS bytes and frame-end markers out.
//
//   channel  | dir | handshake                  | payload
//   ---------+-----+----------------------------+------------------------------
//   bytes in | in  | i_in_valid / o_in_ready    | byte, first, last, length,
//            |     |                            | marker, timestamp
//   results  | out | o_out_valid / i_out_ready  | kind, byte, unit_end,
//            |     |                            | keyframe, timestamp, last
//
// One payload byte is accepted per cycle while the command queue has room.
// A byte causes up to seven results; the back end sends one result per
// cycle unless i_out_ready stalls it, and the queue absorbs start-code
// bursts. A result passes the queue, the back end's step mask and its
// output register. Synchronous reset clears all control state.
// ----------------------------------------------------------------------------
module h264_rtp_depacketizer import h264dp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_byte_first,
    input  logic        i_byte_last,
    input  logic [15:0] i_packet_length,
    input  logic        i_marker,
    input  logic [31:0] i_rtp_timestamp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_unit_end,
    output logic        o_keyframe,
    output logic [31:0] o_frame_timestamp,
    output logic        o_last
);

    logic q_space, q_push, q_valid, q_pop;
    t_cmd push_cmd, head_cmd;

    h264dp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_payload_byte  (i_payload_byte),
        .i_byte_first    (i_byte_first),
        .i_byte_last     (i_byte_last),
        .i_packet_length (i_packet_length),
        .i_marker        (i_marker),
        .i_rtp_timestamp (i_rtp_timestamp),
        .i_space         (q_space),
        .o_push          (q_push),
        .o_cmd           (push_cmd)
    );

    h264dp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_space (q_space),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    h264dp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_cmd           (head_cmd),
        .o_q_pop           (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_out_byte        (o_out_byte),
        .o_unit_end        (o_unit_end),
        .o_keyframe        (o_keyframe),
        .o_frame_timestamp (o_frame_timestamp),
        .o_last            (o_last)
    );

endmodule
